>>> sv/hesd_pkg.sv
// ----------------------------------------------------------------------------
// hesd_pkg
// Shared types and constants of the HTML entity stream decoder: character
// codes, the per-byte class word, queue item layouts and the named entity
// table.
// ----------------------------------------------------------------------------
package hesd_pkg;

    // Character codes that the scanner looks for.
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_RETURN  = 8'h0D;

    // Named entity table: five names of at most six bytes, including the
    // leading ampersand and the closing semicolon.
    localparam int ENT_COUNT   = 5;
    localparam int ENT_MAX_LEN = 6;

    localparam logic [7:0] ENT_NAME [ENT_COUNT][ENT_MAX_LEN] = '{
        '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},   // &amp;
        '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},   // &lt;
        '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},   // &gt;
        '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},   // &quot;
        '{8'h26, 8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B}    // &apos;
    };

    localparam logic [2:0] ENT_LEN [ENT_COUNT] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd6};

    localparam logic [7:0] ENT_CHAR [ENT_COUNT] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27};

    // Class of one text byte, worked out once by the front end.
    typedef struct packed {
        logic       is_amp;
        logic       is_hash;
        logic       is_semi;
        logic       is_x;
        logic       dec_ok;
        logic       hex_ok;
        logic [3:0] digit;
    } byte_class_t;

    // One byte as it sits in the hold ring.
    typedef struct packed {
        logic [7:0]  ch;
        byte_class_t cls;
    } ring_entry_t;

    // One item in the queue between front and back.
    typedef struct packed {
        ring_entry_t ent;
        logic        eot;
    } mid_item_t;

    // One result in the output queue.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } out_item_t;

endpackage

>>> sv/hesd_fifo.sv
// ----------------------------------------------------------------------------
// hesd_fifo
// Small first-in first-out queue built from flip-flops. DEPTH must be a
// power of two. The oldest entry is shown on rd_data while empty is low.
// ----------------------------------------------------------------------------
module hesd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] store [DEPTH];
    logic [AW:0]      wr_ptr_reg;
    logic [AW:0]      wr_ptr_next;
    logic [AW:0]      rd_ptr_reg;
    logic [AW:0]      rd_ptr_next;
    logic             do_write;
    logic             do_read;

    // Status and transfer qualification.
    assign full     = ((wr_ptr_reg - rd_ptr_reg) == (AW+1)'(DEPTH));
    assign empty    = (wr_ptr_reg == rd_ptr_reg);
    assign do_write = wr_en && !full;
    assign do_read  = rd_en && !empty;
    assign rd_data  = store[rd_ptr_reg[AW-1:0]];

    // Pointer advance.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_write)
        begin
            wr_ptr_next = wr_ptr_reg + (AW+1)'(1);
        end
        if (do_read)
        begin
            rd_ptr_next = rd_ptr_reg + (AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            store[wr_ptr_reg[AW-1:0]] <= wr_data;
        end
    end

endmodule

>>> sv/hesd_front.sv
// ----------------------------------------------------------------------------
// hesd_front
// Front end of the decoder: classifies each incoming text byte (ampersand,
// hash, semicolon, hex marker, decimal and hex digit value) and forms the
// queue item handed to the back end.
// ----------------------------------------------------------------------------
module hesd_front
    import hesd_pkg::*;
(
    input  logic       push,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       wr_en,
    output mid_item_t  wr_item
);

    byte_class_t cls;

    // Byte classification.
    always_comb
    begin
        cls         = '0;
        cls.is_amp  = (text_byte == CH_AMP);
        cls.is_hash = (text_byte == CH_HASH);
        cls.is_semi = (text_byte == CH_SEMI);
        cls.is_x    = (text_byte == CH_LOWER_X) || (text_byte == CH_UPPER_X);
        if ((text_byte >= 8'h30) && (text_byte <= 8'h39))
        begin
            cls.dec_ok = 1'b1;
            cls.hex_ok = 1'b1;
            cls.digit  = 4'(text_byte - 8'h30);
        end
        else if ((text_byte >= 8'h61) && (text_byte <= 8'h66))
        begin
            cls.hex_ok = 1'b1;
            cls.digit  = 4'(text_byte - 8'h57);
        end
        else if ((text_byte >= 8'h41) && (text_byte <= 8'h46))
        begin
            cls.hex_ok = 1'b1;
            cls.digit  = 4'(text_byte - 8'h37);
        end
    end

    // Queue item.
    always_comb
    begin
        wr_item.ent.ch  = text_byte;
        wr_item.ent.cls = cls;
        wr_item.eot     = end_of_text;
    end

    assign wr_en = push;

endmodule

>>> sv/hesd_back.sv
// ----------------------------------------------------------------------------
// hesd_back
// Back end of the decoder: keeps the bytes of a pending entity in a small
// ring, scans them one byte per cycle unless the result path stalls, with
// an incremental matcher, emits decoded bytes and rescans on a failed match.
// ----------------------------------------------------------------------------
module hesd_back
    import hesd_pkg::*;
#(
    parameter int MAX_DIGITS = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      mid_empty,
    input  mid_item_t mid_item,
    output logic      mid_pop,
    input  logic      out_full,
    output logic      out_push,
    output out_item_t out_item
);

    localparam int HOLD_DEPTH = ((MAX_DIGITS + 3) > 5) ? (MAX_DIGITS + 3) : 5;
    localparam int PTR_W      = $clog2(HOLD_DEPTH + 1);
    localparam int RING_DEPTH = 1 << PTR_W;
    localparam int JW         = PTR_W + 1;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

    typedef enum logic [1:0] {
        S_WAIT = 2'b01,
        S_SCAN = 2'b10
    } back_state_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_PASS,
        ACT_MORE,
        ACT_MATCH,
        ACT_FAIL
    } scan_act_t;

    ring_entry_t          ring [RING_DEPTH];

    back_state_t          state_reg, state_next;
    logic [JW-1:0]        head_reg, head_next;
    logic [JW-1:0]        tail_reg, tail_next;
    logic [JW-1:0]        j_reg, j_next;
    logic                 fin_reg, fin_next;
    logic                 numeric_reg, numeric_next;
    logic [ENT_COUNT-1:0] mask_reg, mask_next;
    logic                 hex_reg, hex_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [31:0]          val_reg, val_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [7:0]           pend_byte_reg, pend_byte_next;

    logic [JW-1:0]        len;
    logic [PTR_W-1:0]     rd_idx;
    ring_entry_t          ent;
    logic                 at_end;
    logic                 step_done;
    logic                 flush_ok;
    logic                 emit_ok;
    logic                 load;
    scan_act_t            act;
    logic [7:0]           res_byte;

    logic [ENT_COUNT-1:0] eff_mask;
    logic [ENT_COUNT-1:0] name_hit;
    logic [2:0]           name_idx;
    logic                 name_found;
    logic                 name_full;
    logic [7:0]           name_char;

    logic                 num_first;
    logic                 eff_hex;
    logic [CNT_W-1:0]     eff_cnt;
    logic [31:0]          eff_val;
    logic                 digit_ok;
    logic [31:0]          new_val;
    logic [7:0]           num_byte;

    // Ring addressing and scan position.
    assign len       = tail_reg - head_reg;
    assign rd_idx    = head_reg[PTR_W-1:0] + j_reg[PTR_W-1:0];
    assign ent       = ring[rd_idx];
    assign at_end    = (j_reg == len);
    assign step_done = (state_reg == S_SCAN)
                       && ((len == '0)
                           || (at_end && !fin_reg && (len <= JW'(HOLD_DEPTH))));
    assign flush_ok  = !pend_valid_reg || !out_full;
    assign emit_ok   = flush_ok;
    assign load      = !mid_empty
                       && ((state_reg == S_WAIT) || (step_done && flush_ok));
    assign mid_pop   = load;

    // Named entity matcher: entities still consistent with the bytes seen.
    always_comb
    begin
        eff_mask   = (j_reg == JW'(1)) ? '1 : mask_reg;
        name_idx   = (j_reg < JW'(ENT_MAX_LEN)) ? j_reg[2:0] : 3'd0;
        name_found = 1'b0;
        name_full  = 1'b0;
        name_char  = CH_AMP;
        for (int k = 0; k < ENT_COUNT; k++)
        begin
            name_hit[k] = eff_mask[k] && (ENT_NAME[k][name_idx] == ent.ch);
        end
        // The lowest numbered consistent entity decides.
        for (int k = ENT_COUNT - 1; k >= 0; k--)
        begin
            if (name_hit[k])
            begin
                name_found = 1'b1;
                name_full  = (j_reg == (JW'(ENT_LEN[k]) - JW'(1)));
                name_char  = ENT_CHAR[k];
            end
        end
    end

    // Numeric entity matcher: one digit per cycle into a wrapping value.
    always_comb
    begin
        num_first = (j_reg == JW'(2));
        eff_hex   = num_first ? 1'b0 : hex_reg;
        eff_cnt   = num_first ? '0 : cnt_reg;
        eff_val   = num_first ? '0 : val_reg;
        digit_ok  = eff_hex ? ent.cls.hex_ok : ent.cls.dec_ok;
        if (eff_hex)
        begin
            new_val = {eff_val[27:0], ent.cls.digit};
        end
        else
        begin
            new_val = {eff_val[28:0], 3'b000} + {eff_val[30:0], 1'b0}
                      + {28'd0, ent.cls.digit};
        end
        if ((eff_val == 32'd10) || (eff_val == 32'd13))
        begin
            num_byte = CH_NEWLINE;
        end
        else
        begin
            num_byte = eff_val[7:0];
        end
    end

    // Decision for the byte under the scan position.
    always_comb
    begin
        act      = ACT_NONE;
        res_byte = CH_AMP;
        if ((state_reg == S_SCAN) && !step_done)
        begin
            if (at_end)
            begin
                // Unfinished prefix that can no longer be held.
                act = ACT_FAIL;
            end
            else if (j_reg == '0)
            begin
                if (ent.cls.is_amp)
                begin
                    act = ACT_MORE;
                end
                else
                begin
                    act      = ACT_PASS;
                    res_byte = ent.ch;
                end
            end
            else if ((j_reg == JW'(1)) && ent.cls.is_hash)
            begin
                act = ACT_MORE;
            end
            else if ((j_reg != JW'(1)) && numeric_reg)
            begin
                if (num_first && ent.cls.is_x)
                begin
                    act = ACT_MORE;
                end
                else if (digit_ok)
                begin
                    act = (eff_cnt == CNT_W'(MAX_DIGITS)) ? ACT_FAIL : ACT_MORE;
                end
                else if (ent.cls.is_semi)
                begin
                    act      = ACT_MATCH;
                    res_byte = num_byte;
                end
                else
                begin
                    act = ACT_FAIL;
                end
            end
            else
            begin
                if (!name_found)
                begin
                    act = ACT_FAIL;
                end
                else if (name_full)
                begin
                    act      = ACT_MATCH;
                    res_byte = name_char;
                end
                else
                begin
                    act = ACT_MORE;
                end
            end
        end
    end

    // Next state of the scanner, the pending result and the output push.
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        j_next          = j_reg;
        fin_next        = fin_reg;
        numeric_next    = numeric_reg;
        mask_next       = mask_reg;
        hex_next        = hex_reg;
        cnt_next        = cnt_reg;
        val_next        = val_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        out_push        = 1'b0;
        out_item.ch     = pend_byte_reg;
        out_item.last   = 1'b0;

        unique case (state_reg)
            S_WAIT:
            begin
                if (load)
                begin
                    tail_next  = tail_reg + JW'(1);
                    fin_next   = mid_item.eot;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (step_done)
                begin
                    // Close the step: the pending result is its last one.
                    if (flush_ok)
                    begin
                        out_push        = pend_valid_reg;
                        out_item.last   = 1'b1;
                        pend_valid_next = 1'b0;
                        if (load)
                        begin
                            tail_next = tail_reg + JW'(1);
                            fin_next  = mid_item.eot;
                        end
                        else
                        begin
                            state_next = S_WAIT;
                        end
                    end
                end
                else if (act == ACT_MORE)
                begin
                    j_next = j_reg + JW'(1);
                    if (j_reg == JW'(1))
                    begin
                        numeric_next = ent.cls.is_hash;
                        mask_next    = name_hit;
                    end
                    else if (numeric_reg)
                    begin
                        if (num_first && ent.cls.is_x)
                        begin
                            hex_next = 1'b1;
                            cnt_next = '0;
                            val_next = '0;
                        end
                        else
                        begin
                            hex_next = eff_hex;
                            cnt_next = eff_cnt + CNT_W'(1);
                            val_next = new_val;
                        end
                    end
                    else
                    begin
                        mask_next = name_hit;
                    end
                end
                else if ((act == ACT_PASS) || (act == ACT_MATCH) || (act == ACT_FAIL))
                begin
                    if (emit_ok)
                    begin
                        out_push        = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_byte_next  = res_byte;
                        j_next          = '0;
                        if (act == ACT_MATCH)
                        begin
                            head_next = head_reg + j_reg + JW'(1);
                        end
                        else
                        begin
                            head_next = head_reg + JW'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_WAIT;
            head_reg       <= '0;
            tail_reg       <= '0;
            j_reg          <= '0;
            fin_reg        <= 1'b0;
            numeric_reg    <= 1'b0;
            mask_reg       <= '0;
            hex_reg        <= 1'b0;
            cnt_reg        <= '0;
            val_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            j_reg          <= j_next;
            fin_reg        <= fin_next;
            numeric_reg    <= numeric_next;
            mask_reg       <= mask_next;
            hex_reg        <= hex_next;
            cnt_reg        <= cnt_next;
            val_reg        <= val_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload registers: pending byte and ring contents.
    always_ff @(posedge clk)
    begin
        pend_byte_reg <= pend_byte_next;
        if (load)
        begin
            ring[tail_reg[PTR_W-1:0]] <= mid_item.ent;
        end
    end

endmodule

>>> sv/html_entity_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// html_entity_stream_decoder_core
// Streaming HTML character entity decoder with queue-style ports.
// ----------------------------------------------------------------------------
// Input channel: text_byte and end_of_text transfer when push is high and
// full is low. Result channel: out_byte and last_of_run show the oldest
// result while empty is low; it transfers when pop is high.
// Each input byte yields zero or more results; last_of_run marks the final
// result that a byte causes. Bytes that may start an entity are held until
// the match is decided; end_of_text flushes everything still held.
// Flow: in the back-end scanner every byte is first loaded into the hold
// ring and then scanned, whether it passes through, extends a prefix or
// completes an entity. A failed match makes the scanner rescan the held
// bytes, reading the ring one byte per cycle unless the result path
// stalls.
// A plain byte passes the queue between front and back, the hold ring,
// the pending result register and the result queue on its way out.
// Reset clears the queues, the hold ring pointers and the matcher.
// When the receiver stalls, the result queue and then the pending result
// register fill, the scanner stops, and full rises once the queue between
// front and back has filled.
// ----------------------------------------------------------------------------
module html_entity_stream_decoder_core
    import hesd_pkg::*;
#(
    parameter int MAX_DIGITS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 2;

    logic      front_wr;
    mid_item_t front_item;
    logic      mid_empty;
    mid_item_t mid_item;
    logic      mid_pop;
    logic      out_full;
    logic      out_push;
    out_item_t back_item;
    out_item_t res_item;

    // Front end: byte classification.
    hesd_front u_front (
        .push        (push),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .wr_en       (front_wr),
        .wr_item     (front_item)
    );

    // Queue between front and back.
    hesd_fifo #(
        .WIDTH ($bits(mid_item_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_wr),
        .wr_data (front_item),
        .full    (full),
        .rd_en   (mid_pop),
        .rd_data (mid_item),
        .empty   (mid_empty)
    );

    // Back end: entity scanner.
    hesd_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_item  (mid_item),
        .mid_pop   (mid_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_item  (back_item)
    );

    // Result queue.
    hesd_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (back_item),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (res_item),
        .empty   (empty)
    );

    assign out_byte    = res_item.ch;
    assign last_of_run = res_item.last;

endmodule
